// File: sv/lru_demand_paging_unit_macros.svh
// assertion macros for the demand paging unit
`ifndef LRU_DEMAND_PAGING_UNIT_MACROS_SVH
`define LRU_DEMAND_PAGING_UNIT_MACROS_SVH

// same-cycle implication
`define LDP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LDP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ldp_pkg.sv
package ldp_pkg;

  localparam int unsigned VirtualPages = 8;
  localparam int unsigned Frames       = 4;
  localparam int unsigned WordsPerPage = 2;
  localparam int unsigned WordWidth    = 32;

  localparam int unsigned PageW  = $clog2(VirtualPages);
  localparam int unsigned FrameW = $clog2(Frames);
  localparam int unsigned WordW  = (WordsPerPage > 1) ? $clog2(WordsPerPage) : 1;
  localparam int unsigned CntW   = $clog2(WordsPerPage + 1);
  localparam int unsigned DiskDepth  = VirtualPages * WordsPerPage;
  localparam int unsigned FrameDepth = Frames * WordsPerPage;
  localparam int unsigned DiskAw  = PageW + WordW;
  localparam int unsigned FrameAw = FrameW + WordW;

  localparam logic ActRead  = 1'b0;
  localparam logic ActWrite = 1'b1;

  typedef struct packed {
    logic        action;
    logic [3:0]  vaddr;
    logic [30:0] wdata;
  } ldp_req_t;

  typedef struct packed {
    logic signed [31:0] rdata;
    logic               page_fault;
    logic               evicted;
    logic [1:0]         frame_used;
  } ldp_rsp_t;

  typedef enum logic [2:0] {
    StIdle,
    StLookup,
    StEvict,
    StLoad,
    StAccess,
    StResp
  } ldp_state_e;

endpackage

// File: sv/lru_demand_paging_unit.sv
// demand paging unit: 16 virtual words in 8 two-word pages on a disk store,
// 4 main frames holding resident pages, lru replacement.
// request channel: req_i is taken at a rising edge where start_i is high and
// busy_o is low. busy_o stays high until the result has been shown.
// result channel: done_o is high for exactly one cycle with rsp_o valid; the
// receiver must take it then, there is no back pressure.
// steps from the accepting edge to the done_o cycle:
//   hit                    lookup, access, response
//   miss into a free frame lookup, load, access, response
//   miss with write-back   lookup, evict, load, access, response
// a new request can be accepted in the cycle after done_o. the page copies
// go through the single-port disk and frame memories: each page copy moves
// one word per cycle, behind the registered memory read. the page table and
// lru ranks sit in flops and are updated in the lookup cycle.
// reset clears the page table, frame use flags, lru ranks and the disk valid
// flags; unwritten disk words read as all ones. no clearing pass is needed.
`include "lru_demand_paging_unit_macros.svh"

module lru_demand_paging_unit
  import ldp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  ldp_req_t req_i,
  output logic     busy_o,
  output logic     done_o,
  output ldp_rsp_t rsp_o
);

  ldp_state_e state_q, state_d;
  ldp_req_t   req_q;
  logic [CntW-1:0] cnt_q;

  logic [VirtualPages-1:0] ent_vld_q;
  logic [VirtualPages-1:0] ent_dirty_q;
  logic [FrameW-1:0]       ent_frame_q [VirtualPages];
  logic [Frames-1:0]       frm_used_q;
  logic [FrameW-1:0]       frm_rank_q [Frames];
  logic [DiskDepth-1:0]    disk_vld_q;

  logic [FrameW-1:0] f_q;
  logic              fault_q;
  logic              evict_q;
  logic [PageW-1:0]  owner_q;

  // memories
  logic [WordWidth-1:0] disk_mem  [DiskDepth];
  logic [WordWidth-1:0] frame_mem [FrameDepth];
  logic [WordWidth-1:0] disk_rd_q, frame_rd_q;
  logic                 disk_rvld_q;
  logic                 disk_we, disk_re, frame_we, frame_re;
  logic [DiskAw-1:0]    disk_addr;
  logic [FrameAw-1:0]   frame_addr;
  logic [WordWidth-1:0] disk_wdata, frame_wdata;

  // request decode
  logic [PageW-1:0] page;
  logic [WordW-1:0] word;
  assign page = req_q.vaddr[PageW+WordW-1:WordW];
  assign word = req_q.vaddr[WordW-1:0];

  logic [WordW-1:0] cnt_idx, cnt_prev;
  assign cnt_idx  = cnt_q[WordW-1:0];
  assign cnt_prev = WordW'(cnt_q - CntW'(1));

  // lookup: hit, free frame, lru victim and its owner
  logic              lk_hit, lk_free, lk_evict;
  logic [FrameW-1:0] lk_f, lk_free_f, lk_victim;
  logic [FrameW-1:0] lk_old_rank;
  logic [PageW-1:0]  lk_owner;
  logic [FrameW:0]   lk_count;

  always_comb begin
    lk_free   = 1'b0;
    lk_free_f = '0;
    lk_count  = '0;
    lk_victim = '0;
    for (int k = Frames - 1; k >= 0; k--) begin
      if (!frm_used_q[k]) begin
        lk_free   = 1'b1;
        lk_free_f = FrameW'(k);
      end
    end
    for (int k = 0; k < Frames; k++) begin
      lk_count = lk_count + (FrameW + 1)'(frm_used_q[k]);
    end
    for (int k = 1; k < Frames; k++) begin
      if (frm_rank_q[k] > frm_rank_q[lk_victim]) lk_victim = FrameW'(k);
    end
  end

  always_comb begin
    lk_evict = 1'b0;
    lk_owner = '0;
    for (int k = VirtualPages - 1; k >= 0; k--) begin
      if (ent_vld_q[k] && ent_frame_q[k] == lk_victim) begin
        lk_evict = 1'b1;
        lk_owner = PageW'(k);
      end
    end
  end

  always_comb begin
    lk_hit = ent_vld_q[page];
    if (lk_hit) begin
      lk_f        = ent_frame_q[page];
      lk_old_rank = frm_rank_q[lk_f];
    end else if (lk_free) begin
      lk_f        = lk_free_f;
      lk_old_rank = lk_count[FrameW-1:0];
    end else begin
      lk_f        = lk_victim;
      lk_old_rank = frm_rank_q[lk_victim];
    end
  end

  logic miss_evict;
  assign miss_evict = !lk_hit && !lk_free && lk_evict;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (start_i) state_d = StLookup;
      StLookup: begin
        if (lk_hit) state_d = StAccess;
        else if (miss_evict) state_d = StEvict;
        else state_d = StLoad;
      end
      StEvict:  if (cnt_q == CntW'(WordsPerPage)) state_d = StLoad;
      StLoad:   if (cnt_q == CntW'(WordsPerPage)) state_d = StAccess;
      StAccess: state_d = StResp;
      StResp:   state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // memory controls and handshake outputs
  always_comb begin
    disk_we     = 1'b0;
    disk_re     = 1'b0;
    frame_we    = 1'b0;
    frame_re    = 1'b0;
    disk_addr   = '0;
    frame_addr  = '0;
    disk_wdata  = frame_rd_q;
    frame_wdata = disk_rvld_q ? disk_rd_q : '1;
    busy_o      = 1'b1;
    done_o      = 1'b0;
    case (state_q)
      StIdle: busy_o = 1'b0;
      StEvict: begin
        // read frame word cnt, write back the word read in the previous cycle
        frame_re   = cnt_q < CntW'(WordsPerPage);
        frame_addr = {f_q, cnt_idx};
        disk_we    = cnt_q != '0;
        disk_addr  = {owner_q, cnt_prev};
      end
      StLoad: begin
        disk_re    = cnt_q < CntW'(WordsPerPage);
        disk_addr  = {page, cnt_idx};
        frame_we   = cnt_q != '0;
        frame_addr = {f_q, cnt_prev};
      end
      StAccess: begin
        frame_addr  = {f_q, word};
        frame_we    = req_q.action == ActWrite;
        frame_re    = req_q.action == ActRead;
        frame_wdata = WordWidth'(req_q.wdata);
      end
      StResp: done_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (disk_we) disk_mem[disk_addr] <= disk_wdata;
    if (disk_re) disk_rd_q <= disk_mem[disk_addr];
  end

  always_ff @(posedge clk_i) begin
    if (frame_we) frame_mem[frame_addr] <= frame_wdata;
    if (frame_re) frame_rd_q <= frame_mem[frame_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_vld_q  <= '0;
      disk_rvld_q <= 1'b0;
    end else begin
      if (disk_we) disk_vld_q[disk_addr] <= 1'b1;
      if (disk_re) disk_rvld_q <= disk_vld_q[disk_addr];
    end
  end

  // control, page table and lru ranks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      ent_vld_q   <= '0;
      ent_dirty_q <= '0;
      frm_used_q  <= '0;
      for (int k = 0; k < VirtualPages; k++) ent_frame_q[k] <= '0;
      for (int k = 0; k < Frames; k++) frm_rank_q[k] <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_d != state_q) ? '0 : cnt_q + CntW'(1);
      if (state_q == StLookup) begin
        for (int k = 0; k < Frames; k++) begin
          if (FrameW'(k) != lk_f && frm_used_q[k] && frm_rank_q[k] < lk_old_rank) begin
            frm_rank_q[k] <= frm_rank_q[k] + FrameW'(1);
          end
        end
        frm_rank_q[lk_f] <= '0;
        if (!lk_hit) begin
          if (miss_evict) begin
            ent_vld_q[lk_owner]   <= 1'b0;
            ent_dirty_q[lk_owner] <= 1'b0;
          end
          ent_vld_q[page]   <= 1'b1;
          ent_frame_q[page] <= lk_f;
          frm_used_q[lk_f]  <= 1'b1;
        end
        if (req_q.action == ActWrite) ent_dirty_q[page] <= 1'b1;
        else if (!lk_hit) ent_dirty_q[page] <= 1'b0;
      end
    end
  end

  // request and lookup results
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) req_q <= req_i;
    if (state_q == StLookup) begin
      f_q     <= lk_f;
      fault_q <= !lk_hit;
      evict_q <= miss_evict;
      owner_q <= lk_owner;
    end
  end

  always_comb begin
    rsp_o.rdata      = (req_q.action == ActWrite) ? '0 : $signed(frame_rd_q);
    rsp_o.page_fault = fault_q;
    rsp_o.evicted    = evict_q;
    rsp_o.frame_used = f_q;
  end

  `LDP_ASSERT_NEXT(a_done_one_cycle, done_o, !done_o, "result strobe longer than one cycle")
  `LDP_ASSERT_NOW(a_evict_needs_fault, done_o && rsp_o.evicted, rsp_o.page_fault,
                  "eviction without page fault")
  `LDP_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o, "accepted request not busy")
  `LDP_ASSERT_NEXT(a_page_resident, state_q == StLookup, ent_vld_q[page],
                   "page not resident after lookup")
  `LDP_ASSERT_NOW(a_mem_exclusive, 1'b1, !(frame_we && frame_re) && !(disk_we && disk_re),
                  "single port memory read and written together")
  `LDP_ASSERT_NOW(a_dirty_resident, 1'b1, (ent_dirty_q & ~ent_vld_q) == '0,
                  "dirty page not resident")

endmodule
